// ===== hw/rtl/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Shared constants, opcodes and the arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CW               = 36;   // CORDIC x/y datapath width
  localparam int ZW               = 28;   // CORDIC angle accumulator width

  localparam logic [15:0] PI_Q            = 16'd25736;
  localparam logic [15:0] TWO_PI_Q        = 16'd51472;
  localparam logic [15:0] HALF_PI_Q       = 16'd12868;
  localparam logic [15:0] THREE_HALF_PI_Q = 16'd38604;
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_GOAL   = 2'd1,
    OP_TURN   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_LIN_GAIN  = 3'd0;
  localparam logic [2:0] REG_ANG_GAIN  = 3'd1;
  localparam logic [2:0] REG_LIN_LIM   = 3'd2;
  localparam logic [2:0] REG_ANG_LIM   = 3'd3;
  localparam logic [2:0] REG_THRESH    = 3'd4;
  localparam logic [2:0] REG_DEADBAND  = 3'd5;
  localparam logic [2:0] REG_WINDOW    = 3'd6;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0:  r = 28'd13176795;
      5'd1:  r = 28'd7778716;
      5'd2:  r = 28'd4110060;
      5'd3:  r = 28'd2086331;
      5'd4:  r = 28'd1047214;
      5'd5:  r = 28'd524117;
      5'd6:  r = 28'd262123;
      5'd7:  r = 28'd131069;
      5'd8:  r = 28'd65536;
      5'd9:  r = 28'd32768;
      5'd10: r = 28'd16384;
      5'd11: r = 28'd8192;
      5'd12: r = 28'd4096;
      5'd13: r = 28'd2048;
      5'd14: r = 28'd1024;
      5'd15: r = 28'd512;
      5'd16: r = 28'd256;
      5'd17: r = 28'd128;
      5'd18: r = 28'd64;
      5'd19: r = 28'd32;
      5'd20: r = 28'd16;
      5'd21: r = 28'd8;
      5'd22: r = 28'd4;
      5'd23: r = 28'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gtg_cordic.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC arctangent
// Vectoring CORDIC, one micro-rotation per cycle, result in Q3.13 [0, 2pi).
// ----------------------------------------------------------------------------
module gtg_cordic #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [gtg_pkg::CW-1:0] vec_x,
  input  logic signed [gtg_pkg::CW-1:0] vec_y,
  output logic                          done,
  output logic [15:0]                   angle
);

  localparam int NSTEP = (CORDIC_STEPS < gtg_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : gtg_pkg::TABLE_LEN;

  logic signed [gtg_pkg::CW-1:0] x, y;
  logic signed [gtg_pkg::ZW-1:0] z;
  logic [4:0]                    step;
  logic                          busy;
  logic                          zero_vec;

  logic signed [gtg_pkg::CW-1:0] xs, ys;
  logic signed [gtg_pkg::ZW-1:0] az;
  logic signed [gtg_pkg::ZW-1:0] zr;
  logic signed [17:0]            q;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign az = gtg_pkg::atan_entry(step);

  // Round to Q3.13 and wrap into [0, 2pi).
  assign zr = (z + 28'sd1024) >>> 11;
  always_comb begin
    q = zr[17:0];
    if (q < 0) begin
      q = q + 18'sd51472;
    end else if (q >= 18'sd51472) begin
      q = q - 18'sd51472;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        zero_vec <= (vec_x == 0) && (vec_y == 0);
        if (vec_x < 0 && vec_y >= 0) begin
          x <= vec_y;
          y <= -vec_x;
          z <= gtg_pkg::HALF_PI_Q24;
        end else if (vec_x < 0) begin
          x <= -vec_y;
          y <= vec_x;
          z <= -gtg_pkg::HALF_PI_Q24;
        end else begin
          x <= vec_x;
          y <= vec_y;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + az;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - az;
        end
        if (step == 5'(NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign angle = zero_vec ? 16'd0 : q[15:0];

endmodule

// ===== hw/rtl/gtg_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal serial multiplier
// Signed shift-and-add multiplier, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module gtg_serial_mul #(
  parameter int AW = 33,
  parameter int BW = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] prod
);

  localparam int CNTW = $clog2(BW + 1);

  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0]           mplier;
  logic [CNTW-1:0]         cnt;
  logic                    busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= (AW+BW)'(a);
        mplier <= b;
        cnt    <= '0;
      end else if (busy) begin
        // Top bit of a two's complement multiplier has negative weight.
        if (mplier[0]) begin
          if (cnt == CNTW'(BW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNTW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ===== hw/rtl/go_to_goal_p_controller.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal proportional controller
// Heading and forward drive commands from odometry samples and goal commands.
// ----------------------------------------------------------------------------
// Goal and heading commands give no result.
// An odometry sample's result is set by six serial multiplies and one or two
// CORDIC runs, the second only when the heading is re-aimed.
// One item is worked on at a time; input is taken again once the result leaves.
// Synchronous reset restores register defaults and marks the next sample first.
module go_to_goal_p_controller #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic [1:0]         heading_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] linear_speed,
  output logic signed [15:0] angular_speed,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_YAW, S_DIFF, S_AIM, S_ERR,
    S_MA, S_ML, S_SAT, S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] linear_gain, angular_gain;
  logic [14:0]        linear_limit, angular_limit, turn_deadband, drive_window;
  logic [30:0]        reach_threshold;
  logic signed [31:0] goal_x_reg, goal_y_reg;
  logic [15:0]        target_heading;
  logic               first_sample;

  logic signed [31:0] px, py;
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [gtg_pkg::CW-1:0] num, den;
  logic [15:0]        yaw;
  logic signed [32:0] dx, dy;
  logic signed [17:0] err;
  logic signed [15:0] az_r, lx_r;

  // Shared serial multiplier.
  logic               mul_start, mul_done;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;

  gtg_serial_mul #(.AW(33), .BW(17)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  logic               cor_start, cor_done;
  logic signed [gtg_pkg::CW-1:0] cor_x, cor_y;
  logic [15:0]        cor_angle;

  gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .vec_x(cor_x), .vec_y(cor_y),
    .done(cor_done), .angle(cor_angle)
  );

  assign in_ready = (state == S_IDLE);

  // The CORDIC unit takes its vector at the edge where its start is high.
  assign cor_x = (state == S_AIM) ? gtg_pkg::CW'(dx) : den;
  assign cor_y = (state == S_AIM) ? gtg_pkg::CW'(dy) : num;

  logic signed [32:0] adx, ady;
  logic               aim;
  logic signed [17:0] aerr;
  logic signed [17:0] err_raw;
  logic signed [36:0] ang_r;
  logic signed [34:0] lin_r;

  // Tracks whether a CORDIC run has been launched and has not yet finished.
  logic u_cordic_busy;

  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;
  assign aim = (adx > $signed({2'b0, reach_threshold})) &&
               (ady > $signed({2'b0, reach_threshold}));
  assign err_raw = $signed({2'b0, yaw}) - $signed({2'b0, target_heading});
  assign aerr = err[17] ? -err : err;
  assign ang_r = ($signed(mul_p[36:0]) + 37'sd4096) >>> 13;
  assign lin_r = ($signed(mul_p[49:15]) + 35'sd1) >>> 1;

  function automatic logic signed [15:0] sat(input logic signed [36:0] v,
                                             input logic [14:0] lim);
    logic signed [36:0] l;
    l = $signed({22'b0, lim});
    if (v > l) return $signed({1'b0, lim});
    if (v < -l) return -$signed({1'b0, lim});
    return v[15:0];
  endfunction

  // The multiplier takes its operands in the state that follows each start.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1:   begin mul_a = 33'(qw); mul_b = 17'(qz); end
      S_M2:   begin mul_a = 33'(qx); mul_b = 17'(qy); end
      S_M3:   begin mul_a = 33'(qy); mul_b = 17'(qy); end
      S_M4:   begin mul_a = 33'(qz); mul_b = 17'(qz); end
      S_MA:   begin mul_a = 33'(err); mul_b = 17'(angular_gain); end
      S_ML:   begin mul_a = dx; mul_b = 17'(linear_gain); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      mul_start       <= 1'b0;
      cor_start       <= 1'b0;
      linear_gain     <= 16'sd4096;
      angular_gain    <= -16'sd3686;
      linear_limit    <= 15'd2048;
      angular_limit   <= 15'd2048;
      reach_threshold <= 31'd6554;
      turn_deadband   <= 15'd82;
      drive_window    <= 15'd655;
      goal_x_reg      <= '0;
      goal_y_reg      <= '0;
      target_heading  <= '0;
      first_sample    <= 1'b1;
    end else begin
      mul_start <= 1'b0;
      cor_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          gtg_pkg::REG_LIN_GAIN: linear_gain     <= cfg_data[15:0];
          gtg_pkg::REG_ANG_GAIN: angular_gain    <= cfg_data[15:0];
          gtg_pkg::REG_LIN_LIM:  linear_limit    <= cfg_data[14:0];
          gtg_pkg::REG_ANG_LIM:  angular_limit   <= cfg_data[14:0];
          gtg_pkg::REG_THRESH:   reach_threshold <= cfg_data;
          gtg_pkg::REG_DEADBAND: turn_deadband   <= cfg_data[14:0];
          gtg_pkg::REG_WINDOW:   drive_window    <= cfg_data[14:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (opcode)
              gtg_pkg::OP_GOAL: begin
                goal_x_reg <= goal_x;
                goal_y_reg <= goal_y;
              end
              gtg_pkg::OP_TURN: begin
                case (heading_code)
                  2'd0: target_heading <= 16'd0;
                  2'd1: target_heading <= gtg_pkg::HALF_PI_Q;
                  2'd2: target_heading <= gtg_pkg::PI_Q;
                  default: target_heading <= gtg_pkg::THREE_HALF_PI_Q;
                endcase
              end
              gtg_pkg::OP_SAMPLE: begin
                px <= pos_x; py <= pos_y;
                qx <= quat_x; qy <= quat_y; qz <= quat_z; qw <= quat_w;
                mul_start <= 1'b1;
                state <= S_M1;
              end
              default: ;
            endcase
          end
        end
        S_M1: if (mul_done) begin
          num <= gtg_pkg::CW'($signed(mul_p[31:0]));
          mul_start <= 1'b1;
          state <= S_M2;
        end
        S_M2: if (mul_done) begin
          num <= (num + gtg_pkg::CW'($signed(mul_p[31:0]))) <<< 1;
          mul_start <= 1'b1;
          state <= S_M3;
        end
        S_M3: if (mul_done) begin
          den <= gtg_pkg::CW'($signed(mul_p[31:0]));
          mul_start <= 1'b1;
          state <= S_M4;
        end
        S_M4: if (mul_done) begin
          den <= (gtg_pkg::CW'(1) <<< 28) -
                 ((den + gtg_pkg::CW'($signed(mul_p[31:0]))) <<< 1);
          cor_start <= 1'b1;
          state <= S_YAW;
        end
        S_YAW: begin
          if (cor_start == 1'b0 && cor_done) begin
            yaw <= cor_angle;
            if (first_sample) begin
              goal_x_reg     <= px;
              goal_y_reg     <= py;
              target_heading <= cor_angle;
              first_sample   <= 1'b0;
            end
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dx <= 33'(goal_x_reg) - 33'(px);
          dy <= 33'(goal_y_reg) - 33'(py);
          state <= S_AIM;
        end
        S_AIM: begin
          if (aim) begin
            if (!cor_start && cor_done) begin
              target_heading <= cor_angle;
              state <= S_ERR;
              err <= 18'sd0;
            end else if (!cor_start && !u_cordic_busy) begin
              cor_start <= 1'b1;
            end
          end else begin
            state <= S_ERR;
          end
        end
        S_ERR: begin
          if (err_raw >= $signed({2'b0, gtg_pkg::PI_Q})) err <= err_raw - 18'sd51472;
          else if (err_raw < -$signed({2'b0, gtg_pkg::PI_Q})) err <= err_raw + 18'sd51472;
          else err <= err_raw;
          mul_start <= 1'b1;
          state <= S_MA;
        end
        S_MA: if (mul_done) begin
          az_r <= (aerr > $signed({3'b0, turn_deadband})) ?
                  sat(ang_r, angular_limit) : 16'sd0;
          mul_start <= 1'b1;
          state <= S_ML;
        end
        S_ML: if (mul_done) begin
          lx_r <= (aerr < $signed({3'b0, drive_window})) ?
                  sat(37'(lin_r), linear_limit) : 16'sd0;
          state <= S_SAT;
        end
        S_SAT: begin
          linear_speed  <= lx_r;
          angular_speed <= az_r;
          out_valid     <= 1'b1;
          state         <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_cordic_busy <= 1'b0;
    end else if (cor_start) begin
      u_cordic_busy <= 1'b1;
    end else if (cor_done) begin
      u_cordic_busy <= 1'b0;
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input ready while busy");
  a_lin_limit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (linear_speed <= $signed({1'b0, linear_limit})) &&
    (linear_speed >= -$signed({1'b0, linear_limit})))
    else $error("forward speed beyond limit");

endmodule
